// ===== rtl/core/thn_pkg.sv =====
// terrain height noise: shared request/result types, hash and octave constants
// no dependencies; imported by thn_scramble, thn_octave and terrain_height_noise
package thn_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
  } thn_req_t;

  typedef struct packed {
    logic signed [23:0] height;
    logic               was_clamped;
  } thn_res_t;

  localparam int NUM_OCT   = 13;
  localparam int CONT_OCT  = 5;
  localparam int GAIN_OCT  = 4;
  localparam int ROLL_BASE = 5;
  localparam int RIDGE_BASE = 9;

  // octave value width, Q.16
  localparam int NW = 20;

  localparam logic [63:0] SCR_K1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SCR_K2  = 64'h94d049bb133111eb;
  localparam logic [63:0] HASH_CX = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_CZ = 64'h632be59bd9b4e019;

  localparam logic [24:0] OCT_MUL [NUM_OCT] = '{
    25'd343597, 25'd687195, 25'd1374390, 25'd2748779, 25'd5497558,
    25'd1503239, 25'd3156801, 25'd6629282, 25'd13921492,
    25'd3221225, 25'd6603512, 25'd13537200, 25'd27751260
  };

  localparam logic [15:0] CONT_W [CONT_OCT] = '{
    16'd33825, 16'd16913, 16'd8456, 16'd4228, 16'd2114
  };
  localparam logic [15:0] GAIN_W [GAIN_OCT] = '{
    16'd32462, 16'd17854, 16'd9820, 16'd5401
  };

  // quarter-turn sine polynomial, Q16
  localparam logic [16:0] QS_A = 17'd102944;
  localparam logic [15:0] QS_B = 16'd42047;
  localparam logic [12:0] QS_C = 13'd4640;

  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_MIN  = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;

  localparam logic [63:0]        SEED_RST = 64'd0;
  localparam logic signed [23:0] MIN_RST  = -24'sd1048576;
  localparam logic signed [23:0] MAX_RST  = 24'sd2097152;

endpackage

// ===== rtl/core/thn_scramble.sv =====
// terrain height noise: 64-bit mixing hash as a four-stage pipeline
// uses thn_pkg; each 64x64 low product is split into 32x32 partial products
module thn_scramble import thn_pkg::*; (
  input  logic        clk,
  input  logic [63:0] v,
  output logic [63:0] h
);

  logic [63:0] m1, m2;
  logic [63:0] p0a, p0b, sum1, sum2;
  logic [31:0] p1a, p2a, p1b, p2b;

  assign m1 = v ^ (v >> 30);
  assign m2 = sum1 ^ (sum1 >> 27);

  always_ff @(posedge clk) begin
    p0a  <= 64'(m1[31:0]) * 64'(SCR_K1[31:0]);
    p1a  <= m1[31:0] * SCR_K1[63:32];
    p2a  <= m1[63:32] * SCR_K1[31:0];
    sum1 <= p0a + {p1a + p2a, 32'b0};
    p0b  <= 64'(m2[31:0]) * 64'(SCR_K2[31:0]);
    p1b  <= m2[31:0] * SCR_K2[63:32];
    p2b  <= m2[63:32] * SCR_K2[31:0];
    sum2 <= p0b + {p1b + p2b, 32'b0};
  end

  assign h = sum2 ^ (sum2 >> 31);

endmodule

// ===== rtl/core/thn_octave.sv =====
// terrain height noise: one octave of 2D gradient noise, 23-stage pipeline
// uses thn_pkg and thn_scramble; lattice hash, angle sine, fade and blend
module thn_octave import thn_pkg::*; (
  input  logic                 clk,
  input  logic signed [31:0]   px,
  input  logic signed [31:0]   pz,
  input  logic [24:0]          mul,
  input  logic [63:0]          seed,
  output logic signed [NW-1:0] n
);

  logic signed [57:0] prod_x, prod_z;
  logic [31:0] gx0, gx1, gz0, gz1;
  logic [63:0] lane_v [4];
  logic [63:0] lane_h [4];
  logic [63:0] outer_v [4];
  logic [63:0] corner_h [4];
  logic [15:0] tx_d [2:17];
  logic [15:0] tz_d [2:17];

  logic [31:0] phase [4];
  logic [16:0] u12 [8];
  logic [16:0] u13 [8];
  logic [16:0] u14 [8];
  logic [16:0] u15 [8];
  logic [1:0]  q12 [4];
  logic [1:0]  q13 [4];
  logic [1:0]  q14 [4];
  logic [1:0]  q15 [4];
  logic [1:0]  q16 [4];
  logic [33:0] uu [8];
  logic [16:0] u2_13 [8];
  logic [16:0] u2_14 [8];
  logic [29:0] pa [8];
  logic [15:0] inner14 [8];
  logic [32:0] pb [8];
  logic [16:0] mid15 [8];
  logic [33:0] pc [8];
  logic [14:0] sine16 [8];

  logic signed [15:0] sin_a [4];
  logic signed [15:0] sin_b [4];
  logic signed [15:0] sv [4];
  logic signed [15:0] cv [4];
  logic signed [15:0] cs_c [4];
  logic signed [15:0] cs_s [4];
  logic signed [16:0] ox [4];
  logic signed [16:0] oz [4];
  logic signed [32:0] pc18 [4];
  logic signed [32:0] ps18 [4];
  logic signed [34:0] dsum [4];
  logic signed [NW-1:0] corner19 [4];

  logic signed [20:0] fa_x, fa_z;
  logic [15:0] ftt_x, ftt_z;
  logic [31:0] tt_x, tt_z, tc_x, tc_z;
  logic signed [37:0] fbp_x, fbp_z, fbs_x, fbs_z;
  logic [19:0] fb_x, fb_z;
  logic [15:0] fc_x, fc_z;
  logic [35:0] fp_x, fp_z;
  logic [17:0] f19_x, f19_z, fz20, fz21;

  logic signed [NW:0]   diff0, diff1, diff2;
  logic signed [39:0]   d20_0, d20_1, d22;
  logic signed [NW-1:0] n00_20, n01_20, e0_21, e1_21, e0_22;

  assign gx0 = {{14{prod_x[57]}}, prod_x[57:40]};
  assign gz0 = {{14{prod_z[57]}}, prod_z[57:40]};
  assign gx1 = gx0 + 32'd1;
  assign gz1 = gz0 + 32'd1;

  always_ff @(posedge clk) begin
    prod_x <= px * $signed({1'b0, mul});
    prod_z <= pz * $signed({1'b0, mul});
    lane_v[0] <= {32'b0, gx0} + HASH_CX;
    lane_v[1] <= {32'b0, gx1} + HASH_CX;
    lane_v[2] <= {32'b0, gz0} + HASH_CZ;
    lane_v[3] <= {32'b0, gz1} + HASH_CZ;
    tx_d[2] <= prod_x[39:24];
    tz_d[2] <= prod_z[39:24];
    for (int k = 3; k <= 17; k++) begin
      tx_d[k] <= tx_d[k-1];
      tz_d[k] <= tz_d[k-1];
    end
    outer_v[0] <= seed ^ lane_h[0] ^ lane_h[2];
    outer_v[1] <= seed ^ lane_h[1] ^ lane_h[2];
    outer_v[2] <= seed ^ lane_h[0] ^ lane_h[3];
    outer_v[3] <= seed ^ lane_h[1] ^ lane_h[3];
  end

  for (genvar i = 0; i < 4; i++) begin : g_hash
    thn_scramble u_axis (.clk(clk), .v(lane_v[i]), .h(lane_h[i]));
    thn_scramble u_corner (.clk(clk), .v(outer_v[i]), .h(corner_h[i]));
  end

  // angle and quarter-turn sine, lanes 0..3 take x, lanes 4..7 take one minus x
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      phase[c] = (corner_h[c][15:0] == 16'hffff) ? 32'd0
                 : {corner_h[c][15:0], corner_h[c][15:0]};
    end
    for (int j = 0; j < 8; j++) begin
      uu[j] = 34'(u12[j]) * 34'(u12[j]);
      pa[j] = 30'(u2_13[j]) * 30'(QS_C);
      pb[j] = 33'(u2_14[j]) * 33'(inner14[j]);
      pc[j] = 34'(u15[j]) * 34'(mid15[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      u12[c]   <= {1'b0, phase[c][29:14]};
      u12[c+4] <= 17'd65536 - {1'b0, phase[c][29:14]};
      q12[c]   <= phase[c][31:30];
      q13[c]   <= q12[c];
      q14[c]   <= q13[c];
      q15[c]   <= q14[c];
      q16[c]   <= q15[c];
    end
    for (int j = 0; j < 8; j++) begin
      u13[j]     <= u12[j];
      u14[j]     <= u13[j];
      u15[j]     <= u14[j];
      u2_13[j]   <= uu[j][32:16];
      u2_14[j]   <= u2_13[j];
      inner14[j] <= QS_B - {2'b0, pa[j][29:16]};
      mid15[j]   <= QS_A - pb[j][32:16];
      sine16[j]  <= (pc[j][33:17] > 17'd32767) ? 15'h7fff : pc[j][31:17];
    end
  end

  // sign per quadrant, cosine is the sine a quarter turn on
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sin_a[c] = $signed({1'b0, sine16[c]});
      sin_b[c] = $signed({1'b0, sine16[c+4]});
      sv[c] = q16[c][0] ? sin_b[c] : sin_a[c];
      cv[c] = q16[c][0] ? sin_a[c] : sin_b[c];
      ox[c] = $signed({c[0], tx_d[17]});
      oz[c] = $signed({c[1], tz_d[17]});
      dsum[c] = 35'(pc18[c]) + 35'(ps18[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      cs_s[c] <= q16[c][1] ? -sv[c] : sv[c];
      cs_c[c] <= (q16[c][1] ^ q16[c][0]) ? -cv[c] : cv[c];
      pc18[c] <= cs_c[c] * ox[c];
      ps18[c] <= cs_s[c] * oz[c];
      corner19[c] <= dsum[c][NW+14:15];
    end
  end

  // quintic fade
  assign tt_x  = 32'(tx_d[16]) * 32'(tx_d[16]);
  assign tt_z  = 32'(tz_d[16]) * 32'(tz_d[16]);
  assign fbp_x = $signed({1'b0, tx_d[17]}) * fa_x;
  assign fbp_z = $signed({1'b0, tz_d[17]}) * fa_z;
  assign fbs_x = (fbp_x >>> 16) + 38'sd655360;
  assign fbs_z = (fbp_z >>> 16) + 38'sd655360;
  assign tc_x  = 32'(ftt_x) * 32'(tx_d[17]);
  assign tc_z  = 32'(ftt_z) * 32'(tz_d[17]);
  assign fp_x  = 36'(fc_x) * 36'(fb_x);
  assign fp_z  = 36'(fc_z) * 36'(fb_z);

  always_ff @(posedge clk) begin
    fa_x  <= 21'sd6 * $signed({5'b0, tx_d[16]}) - 21'sd983040;
    fa_z  <= 21'sd6 * $signed({5'b0, tz_d[16]}) - 21'sd983040;
    ftt_x <= tt_x[31:16];
    ftt_z <= tt_z[31:16];
    fb_x  <= fbs_x[19:0];
    fb_z  <= fbs_z[19:0];
    fc_x  <= tc_x[31:16];
    fc_z  <= tc_z[31:16];
    f19_x <= fp_x[33:16];
    f19_z <= fp_z[33:16];
  end

  // bilinear blend, x then z
  assign diff0 = (NW+1)'(corner19[1]) - (NW+1)'(corner19[0]);
  assign diff1 = (NW+1)'(corner19[3]) - (NW+1)'(corner19[2]);
  assign diff2 = (NW+1)'(e1_21) - (NW+1)'(e0_21);

  always_ff @(posedge clk) begin
    d20_0  <= diff0 * $signed({1'b0, f19_x});
    d20_1  <= diff1 * $signed({1'b0, f19_x});
    n00_20 <= corner19[0];
    n01_20 <= corner19[2];
    fz20   <= f19_z;
    e0_21  <= NW'(40'(n00_20) + (d20_0 >>> 16));
    e1_21  <= NW'(40'(n01_20) + (d20_1 >>> 16));
    fz21   <= fz20;
    d22    <= diff2 * $signed({1'b0, fz21});
    e0_22  <= e0_21;
    n      <= NW'(40'(e0_22) + (d22 >>> 16));
  end

endmodule

// ===== rtl/core/terrain_height_noise.sv =====
// terrain height noise top level: 13 octave pipelines, layer sums, plateau mask, clamp
// uses thn_pkg, thn_octave (and through it thn_scramble)
//
//  channel   handshake          payload           notes
//  request   start / busy       req (thn_req_t)   taken when start and not busy
//  result    done               result            one cycle strobe, no back-pressure
//  config    cfg_wen            cfg_index/data    seed, min height, max height
//
// one request per cycle; busy stays low
// done runs down the valid chain in step with the result; the depth of that chain is
// set by the octave pipeline (two chained hashes, each two split 64-bit multiplies)
// and the layer sum tree
// synchronous reset clears the valid chain and the seed and height limit registers; nothing can stall
module terrain_height_noise import thn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  thn_req_t    req,
  output logic        busy,
  output logic        done,
  output thn_res_t    result,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int LAT = 33;

  logic [63:0]        noise_seed;
  logic signed [23:0] min_height, max_height;
  logic               accept;
  logic [LAT-1:0]     vld;
  logic signed [31:0] px0, pz0;
  logic signed [NW-1:0] oct_n [NUM_OCT];

  logic signed [36:0] cp [CONT_OCT];
  logic signed [36:0] rp [GAIN_OCT];
  logic signed [NW:0] r_abs [GAIN_OCT];
  logic signed [NW:0] r1 [GAIN_OCT];
  logic signed [41:0] sq [GAIN_OCT];
  logic [23:0]        rr [GAIN_OCT];
  logic [39:0]        mp [GAIN_OCT];
  logic signed [39:0] csa, csb, csc, rsa, rsb, sumc, sumr;
  logic signed [23:0] cont, roll, cont5, roll5;
  logic signed [24:0] cpl;
  logic signed [41:0] mprod, ms;
  logic [16:0]        mask5, mask6;
  logic [40:0]        msa, msb;
  logic [41:0]        msum;
  logic [25:0]        mount6;
  logic [42:0]        mmp;
  logic signed [34:0] hc6, hr6;
  logic [26:0]        mm7;
  logic signed [35:0] hcr7, hcr8;
  logic [37:0]        hm8;
  logic signed [47:0] h16;
  logic signed [39:0] raw9, min_x, max_x;
  thn_res_t           res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[LAT-1];
  assign result = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed <= SEED_RST;
      min_height <= MIN_RST;
      max_height <= MAX_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SEED: noise_seed <= cfg_data;
        REG_MIN:  min_height <= cfg_data[23:0];
        REG_MAX:  max_height <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    px0 <= req.pos_x;
    pz0 <= req.pos_z;
  end

  for (genvar k = 0; k < NUM_OCT; k++) begin : g_oct
    thn_octave u_oct (
      .clk  (clk),
      .px   (px0),
      .pz   (pz0),
      .mul  (OCT_MUL[k]),
      .seed (noise_seed),
      .n    (oct_n[k])
    );
  end

  always_comb begin
    for (int k = 0; k < GAIN_OCT; k++) begin
      r_abs[k] = oct_n[RIDGE_BASE+k][NW-1] ? -((NW+1)'(oct_n[RIDGE_BASE+k]))
                 : (NW+1)'(oct_n[RIDGE_BASE+k]);
      sq[k] = 42'(r1[k]) * 42'(r1[k]);
    end
    sumc  = csa + csb + csc;
    sumr  = rsa + rsb;
    cpl   = 25'(cont) + 25'sd16384;
    mprod = 42'(cpl) * 42'sd52429;
    ms    = mprod >>> 16;
    msum  = 42'(msa) + 42'(msb);
    mmp   = 43'(mount6) * 43'(mask6);
    h16   = 48'(hcr8) + 48'($signed({1'b0, hm8})) - 48'sd2621440;
    min_x = 40'(min_height);
    max_x = 40'(max_height);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CONT_OCT; k++) begin
      cp[k] <= oct_n[k] * $signed({1'b0, CONT_W[k]});
    end
    for (int k = 0; k < GAIN_OCT; k++) begin
      rp[k] <= oct_n[ROLL_BASE+k] * $signed({1'b0, GAIN_W[k]});
      r1[k] <= (NW+1)'(65536) - r_abs[k];
      rr[k] <= sq[k][39:16];
      mp[k] <= 40'(rr[k]) * 40'(GAIN_W[k]);
    end
    csa  <= 40'(cp[0]) + 40'(cp[1]);
    csb  <= 40'(cp[2]) + 40'(cp[3]);
    csc  <= 40'(cp[4]);
    rsa  <= 40'(rp[0]) + 40'(rp[1]);
    rsb  <= 40'(rp[2]) + 40'(rp[3]);
    cont <= sumc[39:16];
    roll <= sumr[39:16];
    if (ms < 0) begin
      mask5 <= 17'd0;
    end else if (ms > 42'sd65536) begin
      mask5 <= 17'd65536;
    end else begin
      mask5 <= ms[16:0];
    end
    msa    <= 41'(mp[0]) + 41'(mp[1]);
    msb    <= 41'(mp[2]) + 41'(mp[3]);
    cont5  <= cont;
    roll5  <= roll;
    mount6 <= msum[41:16];
    mask6  <= mask5;
    hc6    <= 35'(cont5) * 35'sd850;
    hr6    <= 35'(roll5) * 35'sd220;
    mm7    <= mmp[42:16];
    hcr7   <= 36'(hc6) + 36'(hr6);
    hm8    <= 38'(mm7) * 38'd1450;
    hcr8   <= hcr7;
    raw9   <= h16[47:8];
    if (raw9 < min_x) begin
      res_q.height      <= min_height;
      res_q.was_clamped <= 1'b1;
    end else if (raw9 > max_x) begin
      res_q.height      <= max_height;
      res_q.was_clamped <= 1'b1;
    end else begin
      res_q.height      <= raw9[23:0];
      res_q.was_clamped <= 1'b0;
    end
  end

  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    vld[LAT-5] |-> mask6 <= 17'd65536)
    else $error("plateau mask out of range");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    done && !result.was_clamped |->
      (result.height >= min_height) && (result.height <= max_height))
    else $error("unclamped height outside range");

  a_clamp_val: assert property (@(posedge clk) disable iff (rst)
    done && result.was_clamped |->
      (result.height == min_height) || (result.height == max_height))
    else $error("clamped height is not a limit");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without matching request");

endmodule
